// ===== src/pidsep_pkg.sv =====
`timescale 1ns / 1ps

package pidsep_pkg;

  localparam int DW     = 32;          // data width, two's complement
  localparam int FRAC   = 16;          // fraction bits
  localparam int SEP_W  = DW - 1;      // separation limit width
  localparam int PW     = 2 * DW + 1;  // raw product width (kd side has a 33-bit operand)
  localparam int WIDE   = PW + 1;      // working width for scaling and clamping
  localparam int CFG_IW = 3;

  localparam logic signed [DW+1:0] HALF_TURN     = (DW+2)'(180) << FRAC;
  localparam logic signed [DW+1:0] NEG_HALF_TURN = -HALF_TURN;
  localparam logic signed [DW+1:0] FULL_TURN     = (DW+2)'(360) << FRAC;

  // bias that turns the floor of an arithmetic shift into truncation toward zero
  localparam logic signed [WIDE-1:0] TRUNC_BIAS = (WIDE'(1) << FRAC) - WIDE'(1);

  typedef enum logic [CFG_IW-1:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_SEP  = 3'd3,
    REG_WRAP = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DW-1:0] target_value;
    logic signed [DW-1:0] measured_value;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 saturated;
  } out_t;

  typedef struct packed {
    logic signed [DW-1:0] val;
    logic                 clip;
  } term_t;

  // true when v does not fit in DW signed bits
  function automatic logic sat_ovf(input logic signed [WIDE-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[WIDE-1:DW-1];
    all_zero = ~(|v[WIDE-1:DW-1]);
    return !(all_one || all_zero);
  endfunction

  function automatic logic signed [DW-1:0] sat_val(input logic signed [WIDE-1:0] v);
    logic signed [DW-1:0] r;
    if (!sat_ovf(v)) begin
      r = v[DW-1:0];
    end else if (v[WIDE-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== src/pid_step_integral_separation.sv =====
`timescale 1ns / 1ps

// PID controller with integral separation, Q16.16 throughout. Each input
// transaction (target, measured) yields one result transaction (drive,
// saturated). The datapath is a five-stage pipeline: error and wrap, gain
// multiplies, product scaling, integral update, output sum. One transaction
// per cycle is sustained while the output is not stalled; the longest path
// is the gain multiplies in stage two (two 32x32, one 32x33).
// Each stage holds its item independently, so a stalled output backs up the
// pipeline one stage at a time. The integral and the previous error update
// in order as items pass, so results follow the item sequence exactly.
// Configuration writes are always taken (cfg_ready is tied high) and must
// be issued only while the pipeline is empty.
module pid_step_integral_separation (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pidsep_pkg::in_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pidsep_pkg::out_t                 out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pidsep_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [pidsep_pkg::DW-1:0]        cfg_data
);
  import pidsep_pkg::*;

  // configuration
  logic signed [DW-1:0]    kp_r, ki_r, kd_r;
  logic        [SEP_W-1:0] sep_lim_r;
  logic                    wrap_en_r;

  // control
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic ld1, ld2, ld3, ld4, ld5, ld_out;

  // loop state
  logic signed [DW-1:0] integral_r;
  logic signed [DW-1:0] prev_err_r;

  // stage payloads
  in_t                  s1_r;
  logic signed [DW-1:0] s2_err_r;
  logic signed [DW:0]   s2_diff_r;
  logic                 s2_clip_r;
  logic signed [PW-1:0] s3_kp_prod_r, s3_ki_prod_r, s3_kd_prod_r;
  logic                 s3_sep_r, s3_clip_r;
  logic signed [DW-1:0] s4_kp_r, s4_ki_r, s4_kd_r;
  logic                 s4_clip_r, s4_iclip_r, s4_sep_r;
  logic signed [DW-1:0] s5_kp_r, s5_kd_r, s5_integ_r;
  logic                 s5_clip_r, s5_iclip_r;
  out_t                 out_r;

  // combinational
  logic signed [DW+1:0] e_raw, e_wrap;
  logic signed [DW-1:0] err_nxt;
  logic                 err_clip_nxt;
  logic signed [DW:0]   diff_nxt;
  logic        [DW-1:0] err_mag;
  logic                 sep_nxt;
  logic signed [PW-1:0] kp_prod_nxt, ki_prod_nxt, kd_prod_nxt;
  term_t                kp_term, ki_term, kd_term;
  logic signed [DW:0]   isum;
  logic signed [DW-1:0] integ_nxt;
  logic                 iclip_nxt;
  logic signed [DW+1:0] total;
  out_t                 out_nxt;

  // stage handshakes: a stage loads when its predecessor holds an item and
  // it is empty or its own item moves on in the same cycle
  always_comb begin
    ld_out   = v5_r && (!out_valid_r || out_ready);
    ld5      = v4_r && (!v5_r || ld_out);
    ld4      = v3_r && (!v4_r || ld5);
    ld3      = v2_r && (!v3_r || ld4);
    ld2      = v1_r && (!v2_r || ld3);
    in_ready = !v1_r || ld2;
    ld1      = in_valid && in_ready;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 1 -> 2: error, optional single wrap, clamp, difference
  always_comb begin
    e_raw  = (DW+2)'(s1_r.target_value) - (DW+2)'(s1_r.measured_value);
    e_wrap = e_raw;
    if (wrap_en_r) begin
      if (e_raw > HALF_TURN) begin
        e_wrap = e_raw - FULL_TURN;
      end else if (e_raw < NEG_HALF_TURN) begin
        e_wrap = e_raw + FULL_TURN;
      end
    end
    err_nxt      = sat_val(WIDE'(e_wrap));
    err_clip_nxt = sat_ovf(WIDE'(e_wrap));
    diff_nxt     = (DW+1)'(err_nxt) - (DW+1)'(prev_err_r);
  end

  // stage 2 -> 3: multiplies and separation test
  always_comb begin
    err_mag     = s2_err_r[DW-1] ? DW'(-s2_err_r) : DW'(s2_err_r);
    sep_nxt     = err_mag > {1'b0, sep_lim_r};
    kp_prod_nxt = s2_err_r * kp_r;
    ki_prod_nxt = s2_err_r * ki_r;
    kd_prod_nxt = kd_r * s2_diff_r;
  end

  // stage 3 -> 4: scaling
  pidsep_term u_kp_term (.prod(s3_kp_prod_r), .negate(1'b0), .term(kp_term));
  pidsep_term u_ki_term (.prod(s3_ki_prod_r), .negate(1'b0), .term(ki_term));
  pidsep_term u_kd_term (.prod(s3_kd_prod_r), .negate(1'b1), .term(kd_term));

  // stage 4 -> 5: integral recurrence; separation discards the sum and its clip
  always_comb begin
    isum      = (DW+1)'(integral_r) + (DW+1)'(s4_ki_r);
    integ_nxt = sat_val(WIDE'(isum));
    iclip_nxt = s4_iclip_r | sat_ovf(WIDE'(isum));
    if (s4_sep_r) begin
      integ_nxt = '0;
      iclip_nxt = 1'b0;
    end
  end

  // stage 5 -> output
  always_comb begin
    total             = (DW+2)'(s5_kp_r) + (DW+2)'(s5_integ_r) + (DW+2)'(s5_kd_r);
    out_nxt.drive     = sat_val(WIDE'(total));
    out_nxt.saturated = s5_clip_r | s5_iclip_r | sat_ovf(WIDE'(total));
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      prev_err_r  <= '0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      sep_lim_r   <= '0;
      wrap_en_r   <= 1'b0;
    end else begin
      v1_r        <= ld1 | (v1_r & ~ld2);
      v2_r        <= ld2 | (v2_r & ~ld3);
      v3_r        <= ld3 | (v3_r & ~ld4);
      v4_r        <= ld4 | (v4_r & ~ld5);
      v5_r        <= ld5 | (v5_r & ~ld_out);
      out_valid_r <= ld_out | (out_valid_r & ~out_ready);
      if (ld2) begin
        prev_err_r <= err_nxt;
      end
      if (ld5) begin
        integral_r <= integ_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_KP:   kp_r      <= cfg_data;
          REG_KI:   ki_r      <= cfg_data;
          REG_KD:   kd_r      <= cfg_data;
          REG_SEP:  sep_lim_r <= cfg_data[SEP_W-1:0];
          REG_WRAP: wrap_en_r <= cfg_data[0];
          default:  ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_r <= in_data;
    end
    if (ld2) begin
      s2_err_r  <= err_nxt;
      s2_diff_r <= diff_nxt;
      s2_clip_r <= err_clip_nxt;
    end
    if (ld3) begin
      s3_kp_prod_r <= kp_prod_nxt;
      s3_ki_prod_r <= ki_prod_nxt;
      s3_kd_prod_r <= kd_prod_nxt;
      s3_sep_r     <= sep_nxt;
      s3_clip_r    <= s2_clip_r;
    end
    if (ld4) begin
      s4_kp_r    <= kp_term.val;
      s4_ki_r    <= ki_term.val;
      s4_kd_r    <= kd_term.val;
      s4_clip_r  <= s3_clip_r | kp_term.clip | kd_term.clip;
      s4_iclip_r <= ki_term.clip;
      s4_sep_r   <= s3_sep_r;
    end
    if (ld5) begin
      s5_kp_r    <= s4_kp_r;
      s5_kd_r    <= s4_kd_r;
      s5_integ_r <= integ_nxt;
      s5_clip_r  <= s4_clip_r;
      s5_iclip_r <= iclip_nxt;
    end
    if (ld_out) begin
      out_r <= out_nxt;
    end
  end

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> integral_r == '0 && prev_err_r == '0 && !out_valid_r)
    else $error("loop state not cleared by reset");

  a_sep_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ld5 && s4_sep_r |=> integral_r == '0)
    else $error("integral not cleared on separation");

  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    ld2 |=> prev_err_r == s2_err_r)
    else $error("previous error out of step with stage 2");

  a_iclip_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out && s5_iclip_r |=> out_r.saturated)
    else $error("integral clip lost from saturated flag");

  a_stage5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !ld_out |=> v5_r && $stable(s5_integ_r))
    else $error("stage 5 item dropped while stalled");

endmodule

// ===== src/pidsep_term.sv =====
`timescale 1ns / 1ps

// Scales a raw gain product back to Q format: truncate toward zero,
// optional negation, clamp to the data width.
module pidsep_term (
  input  logic signed [pidsep_pkg::PW-1:0] prod,
  input  logic                             negate,
  output pidsep_pkg::term_t                term
);
  import pidsep_pkg::*;

  logic signed [WIDE-1:0] adj;
  logic signed [WIDE-1:0] shifted;
  logic signed [WIDE-1:0] scaled;

  always_comb begin
    adj      = WIDE'(prod) + (prod[PW-1] ? TRUNC_BIAS : WIDE'(0));
    shifted  = adj >>> FRAC;
    scaled   = negate ? -shifted : shifted;
    term.val  = sat_val(scaled);
    term.clip = sat_ovf(scaled);
  end

endmodule
